// ===== hdl/paper_tape_absolute_loader_defines.svh =====
// assertion macros shared by the loader rtl
`ifndef PAPER_TAPE_ABSOLUTE_LOADER_DEFINES_SVH
`define PAPER_TAPE_ABSOLUTE_LOADER_DEFINES_SVH

// condition implies consequence in the same cycle
`define PTAL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define PTAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ptal_pkg.sv =====
package ptal_pkg;

    // parser phase codes
    localparam logic [3:0] PH_HUNT_LO = 4'd0;
    localparam logic [3:0] PH_HUNT_HI = 4'd1;
    localparam logic [3:0] PH_CNT_LO  = 4'd2;
    localparam logic [3:0] PH_CNT_HI  = 4'd3;
    localparam logic [3:0] PH_ADR_LO  = 4'd4;
    localparam logic [3:0] PH_ADR_HI  = 4'd5;
    localparam logic [3:0] PH_DAT_LO  = 4'd6;
    localparam logic [3:0] PH_DAT_HI  = 4'd7;
    localparam logic [3:0] PH_SUM     = 4'd8;

    // result event codes
    localparam logic [1:0] EV_WRITE    = 2'd0;
    localparam logic [1:0] EV_COMPLETE = 2'd1;
    localparam logic [1:0] EV_ERROR    = 2'd2;

    // frame constants
    localparam logic [7:0]  START_BYTE      = 8'd1;
    localparam logic [15:0] HEADER_BYTES    = 16'd6;
    localparam logic [15:0] END_ADDRESS     = 16'd1;

    typedef struct packed {
        logic [7:0] tape_byte;
        logic       end_of_tape;
    } ptal_item_t;

    typedef struct packed {
        logic        emit;
        logic [1:0]  event_res;
        logic [15:0] word_address;
        logic [15:0] word_data;
    } ptal_result_t;

endpackage

// ===== hdl/ptal_parser.sv =====
`include "paper_tape_absolute_loader_defines.svh"

module ptal_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  ptal_pkg::ptal_item_t  item,
    output ptal_pkg::ptal_result_t result
);
    import ptal_pkg::*;

    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  frame_sum_reg, frame_sum_next;
    logic [15:0] frame_count_reg, frame_count_next;
    logic [15:0] write_pointer_reg, write_pointer_next;
    logic [14:0] words_left_reg, words_left_next;
    logic [7:0]  held_low_byte_reg, held_low_byte_next;
    logic        finished_reg, finished_next;

    logic [15:0] word_val;
    logic [7:0]  sum_add;
    logic [15:0] data_len;
    logic [14:0] words_dec;

    assign word_val  = {item.tape_byte, held_low_byte_reg};
    assign sum_add   = frame_sum_reg + item.tape_byte;
    assign data_len  = frame_count_reg - HEADER_BYTES;
    assign words_dec = words_left_reg - 15'd1;

    // next state and result for one tape byte
    always_comb
    begin
        phase_next         = phase_reg;
        frame_sum_next     = frame_sum_reg;
        frame_count_next   = frame_count_reg;
        write_pointer_next = write_pointer_reg;
        words_left_next    = words_left_reg;
        held_low_byte_next = held_low_byte_reg;
        finished_next      = finished_reg;
        result             = '0;

        if (step && !finished_reg)
        begin
            if (item.end_of_tape)
            begin
                finished_next = 1'b1;
                result.emit   = 1'b1;
                if (phase_reg == PH_HUNT_LO || phase_reg == PH_HUNT_HI)
                    result.event_res = EV_COMPLETE;
                else
                    result.event_res = EV_ERROR;
            end
            else
            begin
                case (phase_reg)
                    PH_HUNT_LO:
                    begin
                        if (item.tape_byte == START_BYTE)
                        begin
                            frame_sum_next = START_BYTE;
                            phase_next     = PH_HUNT_HI;
                        end
                    end
                    PH_HUNT_HI:
                    begin
                        frame_sum_next = sum_add;
                        phase_next     = (item.tape_byte == 8'd0) ? PH_CNT_LO : PH_HUNT_LO;
                    end
                    PH_CNT_LO, PH_ADR_LO, PH_DAT_LO:
                    begin
                        frame_sum_next     = sum_add;
                        held_low_byte_next = item.tape_byte;
                        phase_next         = phase_reg + 4'd1;
                    end
                    PH_CNT_HI:
                    begin
                        frame_sum_next   = sum_add;
                        frame_count_next = word_val;
                        phase_next       = PH_ADR_LO;
                    end
                    PH_ADR_HI:
                    begin
                        frame_sum_next     = sum_add;
                        write_pointer_next = word_val;
                        if (word_val == END_ADDRESS)
                        begin
                            finished_next    = 1'b1;
                            result.emit      = 1'b1;
                            result.event_res = EV_COMPLETE;
                        end
                        else if (frame_count_reg == 16'd0)
                        begin
                            phase_next = PH_HUNT_LO;
                        end
                        else if (data_len[0])
                        begin
                            finished_next    = 1'b1;
                            result.emit      = 1'b1;
                            result.event_res = EV_ERROR;
                        end
                        else
                        begin
                            words_left_next    = data_len[15:1];
                            write_pointer_next = {1'b0, word_val[15:1]};
                            phase_next = (data_len[15:1] != 15'd0) ? PH_DAT_LO : PH_SUM;
                        end
                    end
                    PH_DAT_HI:
                    begin
                        frame_sum_next      = sum_add;
                        write_pointer_next  = write_pointer_reg + 16'd1;
                        words_left_next     = words_dec;
                        phase_next          = (words_dec != 15'd0) ? PH_DAT_LO : PH_SUM;
                        result.emit         = 1'b1;
                        result.event_res    = EV_WRITE;
                        result.word_address = write_pointer_reg;
                        result.word_data    = word_val;
                    end
                    PH_SUM:
                    begin
                        frame_sum_next = sum_add;
                        if (sum_add != 8'd0)
                        begin
                            finished_next    = 1'b1;
                            result.emit      = 1'b1;
                            result.event_res = EV_ERROR;
                        end
                        else
                        begin
                            phase_next = PH_HUNT_LO;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT_LO;
                    end
                endcase
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT_LO;
            frame_sum_reg     <= '0;
            frame_count_reg   <= '0;
            write_pointer_reg <= '0;
            words_left_reg    <= '0;
            held_low_byte_reg <= '0;
            finished_reg      <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            frame_sum_reg     <= frame_sum_next;
            frame_count_reg   <= frame_count_next;
            write_pointer_reg <= write_pointer_next;
            words_left_reg    <= words_left_next;
            held_low_byte_reg <= held_low_byte_next;
            finished_reg      <= finished_next;
        end
    end

    // checks
    `PTAL_ASSERT_NEXT(a_finished_sticks, finished_reg, finished_reg,
        "loader left the finished state without reset")
    `PTAL_ASSERT_SAME(a_write_from_data, result.emit && result.event_res == EV_WRITE,
        phase_reg == PH_DAT_HI, "word write outside a data high byte")
    `PTAL_ASSERT_NEXT(a_stop_finishes, result.emit && result.event_res != EV_WRITE,
        finished_reg, "complete or error did not stop the loader")
    `PTAL_ASSERT_SAME(a_data_has_words, phase_reg == PH_DAT_LO || phase_reg == PH_DAT_HI,
        words_left_reg != 15'd0, "data phase with no words left")

endmodule

// ===== hdl/paper_tape_absolute_loader.sv =====
// Absolute paper-tape loader: takes one tape byte (or an end-of-tape mark) per
// transaction and reports word writes, load complete or tape error. One byte
// is accepted every cycle unless the result register stalls; a byte sits in
// the input register while the parser works on it, and its result is then
// registered in the result register that drives the result channel. The only
// stall comes from the result register: when it holds an undelivered
// transaction and res_ready is low, the pending byte in the input register
// waits and tape_ready drops. After complete or error all further bytes are
// accepted and dropped until reset.
`include "paper_tape_absolute_loader_defines.svh"

module paper_tape_absolute_loader (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tape_valid,
    output logic        tape_ready,
    input  logic [7:0]  tape_byte,
    input  logic        end_of_tape,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [1:0]  event_res,
    output logic [15:0] word_address,
    output logic [15:0] word_data
);
    import ptal_pkg::*;

    logic         item_valid_reg, item_valid_next;
    ptal_item_t   item_reg;
    logic         res_valid_reg, res_valid_next;
    ptal_result_t res_reg;
    ptal_result_t step_result;
    logic         advance;

    // input register moves into the result slot when it is free or draining
    assign advance    = item_valid_reg && (!res_valid_reg || res_ready);
    assign tape_ready = !item_valid_reg || advance;

    ptal_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .result (step_result)
    );

    // valid flags
    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (tape_valid && tape_ready)
            item_valid_next = 1'b1;
        else if (advance)
            item_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = step_result.emit;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (tape_valid && tape_ready)
        begin
            item_reg.tape_byte   <= tape_byte;
            item_reg.end_of_tape <= end_of_tape;
        end
        if (advance)
            res_reg <= step_result;
    end

    assign res_valid    = res_valid_reg;
    assign event_res    = res_reg.event_res;
    assign word_address = res_reg.word_address;
    assign word_data    = res_reg.word_data;

    // checks
    `PTAL_ASSERT_NEXT(a_stall_holds_item, item_valid_reg && !advance,
        item_valid_reg && $stable(item_reg), "pending tape byte lost during stall")
    `PTAL_ASSERT_SAME(a_ready_when_free, !item_valid_reg, tape_ready,
        "empty input register refused a transaction")
    `PTAL_ASSERT_NEXT(a_emit_shows, advance && step_result.emit, res_valid,
        "parser result did not reach the result channel")

endmodule

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ptal_pkg::*;

    // one predicted loader event
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [15:0] data;
    } load_event_t;

    // ways the load is brought to its end
    typedef enum int {
        END_HUNT_EOT,
        END_FRAME_EOT,
        END_ADDR_ONE,
        END_ODD_LEN,
        END_BAD_SUM
    } end_case_t;

    localparam int unsigned RANDOM_PER_PHASE = 170;
    localparam int unsigned LONG_STALL_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        tape_valid = 1'b0;
    logic        tape_ready;
    logic [7:0]  tape_byte = 8'h00;
    logic        end_of_tape = 1'b0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [1:0]  event_res;
    logic [15:0] word_address;
    logic [15:0] word_data;

    // stimulus and expected events
    ptal_item_t  tape_queue[$];
    load_event_t pending_events[$];
    ptal_item_t  next_tape_item;
    load_event_t next_event;
    logic        tape_taken = 1'b0;

    // idling control
    int unsigned send_idle_pct = 0;
    int unsigned res_stall_pct = 0;
    bit          long_stall_go = 1'b0;
    bit          long_stall = 1'b0;

    // bookkeeping
    int unsigned items_queued = 0;
    int unsigned bytes_accepted = 0;
    int unsigned writes_checked = 0;
    int unsigned events_checked = 0;
    int          mismatch_count = 0;
    end_case_t   end_case;

    // loader state as predicted
    logic [3:0]  ld_phase = PH_HUNT_LO;
    logic [7:0]  ld_sum = 8'h00;
    logic [15:0] ld_count = 16'h0000;
    logic [15:0] ld_ptr = 16'h0000;
    logic [14:0] ld_words = 15'h0000;
    logic [7:0]  ld_low = 8'h00;
    bit          ld_done = 1'b0;

    paper_tape_absolute_loader i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tape_valid   (tape_valid),
        .tape_ready   (tape_ready),
        .tape_byte    (tape_byte),
        .end_of_tape  (end_of_tape),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .event_res    (event_res),
        .word_address (word_address),
        .word_data    (word_data)
    );

    always #2 clk = ~clk;

    // advance the predicted parser by one tape byte, report whether an event results
    function automatic bit parse_tape_byte(input logic [7:0] b, input logic eot,
                                           output load_event_t ev);
        logic [15:0] w;
        logic [15:0] len;
        ev = '0;
        if (ld_done)
            return 1'b0;
        // end of tape completes the load only while hunting
        if (eot)
        begin
            ld_done = 1'b1;
            ev.kind = (ld_phase == PH_HUNT_LO || ld_phase == PH_HUNT_HI) ? EV_COMPLETE
                                                                         : EV_ERROR;
            return 1'b1;
        end
        w = {b, ld_low};
        case (ld_phase)
            PH_HUNT_LO:
            begin
                if (b == START_BYTE)
                begin
                    ld_sum = START_BYTE;
                    ld_phase = PH_HUNT_HI;
                end
            end
            PH_HUNT_HI:
            begin
                ld_sum = ld_sum + b;
                ld_phase = (b == 8'h00) ? PH_CNT_LO : PH_HUNT_LO;
            end
            PH_CNT_LO, PH_ADR_LO, PH_DAT_LO:
            begin
                ld_sum = ld_sum + b;
                ld_low = b;
                ld_phase = ld_phase + 4'd1;
            end
            PH_CNT_HI:
            begin
                ld_sum = ld_sum + b;
                ld_count = w;
                ld_phase = PH_ADR_LO;
            end
            PH_ADR_HI:
            begin
                ld_sum = ld_sum + b;
                ld_ptr = w;
                if (w == END_ADDRESS)
                begin
                    ld_done = 1'b1;
                    ev.kind = EV_COMPLETE;
                    return 1'b1;
                end
                if (ld_count == 16'h0000)
                begin
                    ld_phase = PH_HUNT_LO;
                    return 1'b0;
                end
                len = ld_count - HEADER_BYTES;
                if (len[0])
                begin
                    ld_done = 1'b1;
                    ev.kind = EV_ERROR;
                    return 1'b1;
                end
                ld_words = len[15:1];
                ld_ptr = ld_ptr >> 1;
                ld_phase = (ld_words != 15'h0000) ? PH_DAT_LO : PH_SUM;
            end
            PH_DAT_HI:
            begin
                ld_sum = ld_sum + b;
                ev.kind = EV_WRITE;
                ev.addr = ld_ptr;
                ev.data = w;
                ld_ptr = ld_ptr + 16'd1;
                ld_words = ld_words - 15'd1;
                ld_phase = (ld_words != 15'h0000) ? PH_DAT_LO : PH_SUM;
                return 1'b1;
            end
            PH_SUM:
            begin
                ld_sum = ld_sum + b;
                if (ld_sum != 8'h00)
                begin
                    ld_done = 1'b1;
                    ev.kind = EV_ERROR;
                    return 1'b1;
                end
                ld_phase = PH_HUNT_LO;
            end
            default:
                ld_phase = PH_HUNT_LO;
        endcase
        return 1'b0;
    endfunction

    // stimulus helpers
    task automatic push_item(input logic [7:0] b, input logic eot);
        ptal_item_t it;
        it.tape_byte = b;
        it.end_of_tape = eot;
        tape_queue.push_back(it);
        items_queued++;
    endtask

    function automatic logic [15:0] pick_address();
        logic [15:0] a;
        a = 16'($urandom_range(65535));
        if (a == END_ADDRESS)
            a = 16'hFFFF;
        return a;
    endfunction

    // a whole frame; fill below zero means random data
    task automatic push_frame(input logic [15:0] count, input logic [15:0] addr,
                              input bit bad_sum, input int fill);
        logic [7:0]  sum;
        logic [7:0]  b;
        logic [15:0] len;
        push_item(START_BYTE, 1'b0);
        push_item(8'h00, 1'b0);
        push_item(count[7:0], 1'b0);
        push_item(count[15:8], 1'b0);
        push_item(addr[7:0], 1'b0);
        push_item(addr[15:8], 1'b0);
        sum = START_BYTE + count[7:0] + count[15:8] + addr[7:0] + addr[15:8];
        len = count - HEADER_BYTES;
        // end address, empty count and odd length all stop at the header
        if (addr == END_ADDRESS || count == 16'h0000 || len[0])
            return;
        for (int unsigned i = 0; i < len; i++)
        begin
            b = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
            push_item(b, 1'b0);
            sum = sum + b;
        end
        b = 8'h00 - sum;
        if (bad_sum)
            b = b + 8'($urandom_range(1, 255));
        push_item(b, 1'b0);
    endtask

    // hunt noise: a stray byte, or a start byte followed by a non-zero byte
    task automatic push_noise();
        logic [7:0] b;
        if ($urandom_range(1))
        begin
            do
                b = 8'($urandom_range(255));
            while (b == START_BYTE);
            push_item(b, 1'b0);
        end
        else
        begin
            push_item(START_BYTE, 1'b0);
            push_item(8'($urandom_range(1, 255)), 1'b0);
        end
    endtask

    // wait until every queued byte is taken and every expected event has arrived
    task automatic drain_all();
        do
            @(negedge clk);
        while (bytes_accepted != items_queued || pending_events.size() != 0);
        @(posedge clk);
    endtask

    // tape driver
    always @(negedge clk)
    begin
        if (!rst_n)
            tape_valid <= 1'b0;
        else if (!tape_valid || tape_taken)
        begin
            if (tape_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_tape_item = tape_queue.pop_front();
                tape_valid <= 1'b1;
                tape_byte <= next_tape_item.tape_byte;
                end_of_tape <= next_tape_item.end_of_tape;
            end
            else
                tape_valid <= 1'b0;
        end
    end

    // result ready driver
    always @(negedge clk)
        res_ready <= !long_stall && ($urandom_range(99) >= res_stall_pct);

    // long result hold-off so the loader backs up into its input
    initial
    begin
        wait (long_stall_go);
        @(posedge clk);
        long_stall = 1'b1;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
        long_stall = 1'b0;
    end

    // monitor: check results, predict from accepted tape bytes
    always @(posedge clk)
    begin
        tape_taken <= tape_valid && tape_ready;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_events.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result: event %0d address %h data %h",
                             event_res, word_address, word_data);
                mismatch_count++;
            end
            else
            begin
                next_event = pending_events.pop_front();
                if (event_res !== next_event.kind || word_address !== next_event.addr ||
                    word_data !== next_event.data)
                begin
                    if (mismatch_count < 10)
                        $display("mismatch: expected event %0d address %h data %h, got %0d %h %h",
                                 next_event.kind, next_event.addr, next_event.data,
                                 event_res, word_address, word_data);
                    mismatch_count++;
                end
                else if (next_event.kind == EV_WRITE)
                    writes_checked++;
                else
                    events_checked++;
            end
        end
        if (rst_n && tape_valid && tape_ready)
        begin
            bytes_accepted++;
            if (parse_tape_byte(tape_byte, end_of_tape, next_event))
                pending_events.push_back(next_event);
        end
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // main sequence
    initial
    begin
        int unsigned send_idle_tbl[4];
        int unsigned res_stall_tbl[4];
        int unsigned start_mark;
        int unsigned frame_size;
        int unsigned pick;
        logic [15:0] cut_count;
        logic [15:0] cut_addr;
        send_idle_tbl = '{0, 50, 0, 28};
        res_stall_tbl = '{0, 0, 50, 28};
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = send_idle_tbl[ph];
            res_stall_pct = res_stall_tbl[ph];
            if (ph == 0)
            begin
                // directed: hunt extremes, second start byte of one and of all ones
                push_item(8'h00, 1'b0);
                push_item(8'hFF, 1'b0);
                push_item(START_BYTE, 1'b0);
                push_item(START_BYTE, 1'b0);
                push_item(START_BYTE, 1'b0);
                push_item(8'hFF, 1'b0);
                // header-only frame, empty count, top address with all-ones data
                push_frame(HEADER_BYTES, 16'h0000, 1'b0, -1);
                push_frame(16'h0000, 16'hFFFF, 1'b0, -1);
                push_frame(16'd8, 16'hFFFF, 1'b0, 8'hFF);
                long_stall_go = 1'b1;
            end
            start_mark = items_queued;
            while (items_queued - start_mark < RANDOM_PER_PHASE)
            begin
                pick = $urandom_range(9);
                if (pick < 2)
                    push_noise();
                else if (pick == 2)
                    push_frame(16'h0000, pick_address(), 1'b0, -1);
                else
                    push_frame(16'(6 + 2 * $urandom_range(0, 12)), pick_address(), 1'b0, -1);
            end
            drain_all();
        end

        // bring the load to its end in one of the terminal ways
        end_case = end_case_t'($urandom_range(4));
        case (end_case)
            END_HUNT_EOT:
            begin
                if ($urandom_range(1))
                    push_item(START_BYTE, 1'b0);
                push_item(8'($urandom_range(255)), 1'b1);
            end
            END_FRAME_EOT:
            begin
                if ($urandom_range(1))
                begin
                    // count below header size wraps into a very long data run, cut short
                    cut_count = 16'(2 + 2 * $urandom_range(1));
                    cut_addr = pick_address();
                    push_item(START_BYTE, 1'b0);
                    push_item(8'h00, 1'b0);
                    push_item(cut_count[7:0], 1'b0);
                    push_item(cut_count[15:8], 1'b0);
                    push_item(cut_addr[7:0], 1'b0);
                    push_item(cut_addr[15:8], 1'b0);
                    repeat ($urandom_range(2, 24))
                        push_item(8'($urandom_range(255)), 1'b0);
                end
                else
                begin
                    start_mark = items_queued;
                    push_frame(16'(6 + 2 * $urandom_range(0, 6)), pick_address(), 1'b0, -1);
                    frame_size = items_queued - start_mark;
                    repeat ($urandom_range(1, frame_size - 2))
                    begin
                        void'(tape_queue.pop_back());
                        items_queued--;
                    end
                end
                push_item(8'($urandom_range(255)), 1'b1);
            end
            END_ADDR_ONE:
                push_frame(16'($urandom_range(65535)), END_ADDRESS, 1'b0, -1);
            END_ODD_LEN:
                push_frame(16'($urandom_range(65535)) | 16'h0001, pick_address(), 1'b0, -1);
            default:
                push_frame(16'(6 + 2 * $urandom_range(0, 6)), pick_address(), 1'b1, -1);
        endcase
        // everything after the end is dropped by the loader
        repeat (12)
            push_item(8'($urandom_range(255)), 1'($urandom_range(1)));
        drain_all();
        repeat (20) @(posedge clk);

        $display("summary: %0d tape bytes, %0d word writes and %0d end events checked",
                 bytes_accepted, writes_checked, events_checked);
        $display("summary: four idling phases, one long result stall, load ended by %s",
                 end_case.name());
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
